// ===== sv/srb_pkg.sv =====
// Shared types and constants of the shifted-row blitter.
// No dependencies; every other file of the block uses this package.
package srb_pkg;

    localparam int DEF_WORDS_PER_LINE = 20;
    localparam int DEF_LINES          = 400;

    localparam int WORD_BITS = 32;
    localparam int SHIFT_W   = 5;
    localparam int ACTION_W  = 2;
    localparam int XPOS_W    = 11;
    localparam int ROW_W     = 9;
    localparam int RIDX_W    = 13;

    typedef enum logic [ACTION_W-1:0] {
        ACT_OR   = 2'd0,
        ACT_XOR  = 2'd1,
        ACT_AND  = 2'd2,
        ACT_READ = 2'd3
    } t_action;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic load;
        logic rd_l;
        logic rd_r;
        logic wr_l;
        logic wr_r;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_dp_stat;

    function automatic logic [WORD_BITS-1:0] combine(
        input t_action               op,
        input logic [WORD_BITS-1:0]  old_word,
        input logic [WORD_BITS-1:0]  term
    );
        logic [WORD_BITS-1:0] res;
        case (op)
            ACT_OR:  res = old_word | term;
            ACT_XOR: res = old_word ^ term;
            default: res = old_word & term;
        endcase
        return res;
    endfunction

endpackage

// ===== sv/srb_if.sv =====
// Channel interfaces of the shifted-row blitter: sprite row items in, results out.
// Widths come from srb_pkg.
interface srb_item_if;
    logic                          valid;
    logic                          ready;
    logic [srb_pkg::ACTION_W-1:0]  action;
    logic signed [srb_pkg::XPOS_W-1:0] x_pos;
    logic [srb_pkg::ROW_W-1:0]     row_pos;
    logic [srb_pkg::WORD_BITS-1:0] pattern;
    logic [srb_pkg::RIDX_W-1:0]    read_index;
    logic                          last_row;

    modport source(output valid, action, x_pos, row_pos, pattern, read_index, last_row,
                   input ready);
    modport sink(input valid, action, x_pos, row_pos, pattern, read_index, last_row,
                 output ready);
endinterface

interface srb_result_if;
    logic                          valid;
    logic                          ready;
    logic [srb_pkg::WORD_BITS-1:0] read_data;
    logic                          sprite_done;

    modport source(output valid, read_data, sprite_done, input ready);
    modport sink(input valid, read_data, sprite_done, output ready);
endinterface

// ===== sv/srb_ctrl.sv =====
// Sequencing controller of the shifted-row blitter: clearing pass, then the
// read-modify-write steps of each item. Depends on srb_pkg.
module srb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  srb_pkg::t_dp_stat i_stat,
    output srb_pkg::t_dp_cmd  o_cmd
);
    import srb_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RD_L  = 5'b00100,
        S_RD_R  = 5'b01000,
        S_WR_R  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD_L;
                end
            end
            S_RD_L: begin
                o_cmd.rd_l = 1'b1;
                n_state    = S_RD_R;
            end
            S_RD_R: begin
                // The left word is written back while the right word is read.
                o_cmd.wr_l = 1'b1;
                o_cmd.rd_r = 1'b1;
                n_state    = S_WR_R;
            end
            S_WR_R: begin
                // Repeating this write while the result port is full is harmless,
                // because the old word stays in the read register.
                o_cmd.wr_r = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== sv/srb_dpath.sv =====
// Datapath of the shifted-row blitter: item registers, address and shift logic,
// the frame store memory and the result register. Depends on srb_pkg.
module srb_dpath #(
    parameter int WORDS_PER_LINE = srb_pkg::DEF_WORDS_PER_LINE,
    parameter int LINES          = srb_pkg::DEF_LINES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  srb_pkg::t_dp_cmd                    i_cmd,
    output srb_pkg::t_dp_stat                   o_stat,
    input  logic [srb_pkg::ACTION_W-1:0]        i_action,
    input  logic signed [srb_pkg::XPOS_W-1:0]   i_x_pos,
    input  logic [srb_pkg::ROW_W-1:0]           i_row_pos,
    input  logic [srb_pkg::WORD_BITS-1:0]       i_pattern,
    input  logic [srb_pkg::RIDX_W-1:0]          i_read_index,
    input  logic                                i_last_row,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [srb_pkg::WORD_BITS-1:0]       o_read_data,
    output logic                                o_sprite_done
);
    import srb_pkg::*;

    localparam int STORE_WORDS = WORDS_PER_LINE * LINES;
    localparam int AW          = $clog2(STORE_WORDS);
    localparam int WL_W        = $clog2(WORDS_PER_LINE + 1);
    localparam int PW          = ROW_W + WL_W;
    localparam int COL_W       = XPOS_W - SHIFT_W;

    logic [WORD_BITS-1:0] r_mem [STORE_WORDS];
    logic [WORD_BITS-1:0] r_mem_q;

    logic [AW-1:0]        r_clr_cnt;
    t_action              r_op;
    logic                 r_last;
    logic                 r_rd_ok;
    logic                 r_rd_l_en;
    logic                 r_wr_l_en;
    logic                 r_wr_r_en;
    logic [AW-1:0]        r_addr_a;
    logic [AW-1:0]        r_addr_l;
    logic [AW-1:0]        r_addr_r;
    logic [WORD_BITS-1:0] r_lterm;
    logic [WORD_BITS-1:0] r_rterm;
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_out_data;
    logic                 r_out_done;

    // Address, guard and shift logic for the item being accepted.
    logic [COL_W-1:0]     col_l;
    logic [COL_W:0]       col_r;
    logic [SHIFT_W-1:0]   shamt;
    logic [PW-1:0]        base;
    logic                 row_ok;
    logic                 col_l_ok;
    logic                 col_r_ok;
    logic                 idx_ok;
    logic                 is_read;
    logic [WORD_BITS-1:0] lterm;
    logic [WORD_BITS-1:0] rterm;

    always_comb begin
        col_l    = i_x_pos[XPOS_W-1:SHIFT_W];
        col_r    = {col_l[COL_W-1], col_l} + (COL_W+1)'(1);
        shamt    = i_x_pos[SHIFT_W-1:0];
        base     = PW'(i_row_pos) * PW'(WORDS_PER_LINE);
        row_ok   = 32'(i_row_pos) < LINES;
        col_l_ok = !col_l[COL_W-1] && (32'(col_l[COL_W-2:0]) < WORDS_PER_LINE);
        col_r_ok = !col_r[COL_W] && (32'(col_r[COL_W-1:0]) < WORDS_PER_LINE);
        idx_ok   = 32'(i_read_index) < STORE_WORDS;
        is_read  = t_action'(i_action) == ACT_READ;
        lterm    = i_pattern >> shamt;
        // With no shift the row lies wholly in the left word.
        if (shamt == '0) begin
            rterm = '0;
        end else begin
            rterm = i_pattern << ((SHIFT_W+1)'(WORD_BITS) - {1'b0, shamt});
        end
    end

    // Memory port selection.
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    always_comb begin
        rd_en   = (i_cmd.rd_l && r_rd_l_en) || (i_cmd.rd_r && r_wr_r_en);
        rd_addr = i_cmd.rd_r ? r_addr_r : r_addr_a;
        wr_en   = i_cmd.clr_wr || (i_cmd.wr_l && r_wr_l_en) || (i_cmd.wr_r && r_wr_r_en);
        if (i_cmd.clr_wr) begin
            wr_addr = r_clr_cnt;
            wr_data = '0;
        end else if (i_cmd.wr_l) begin
            wr_addr = r_addr_l;
            wr_data = combine(r_op, r_mem_q, r_lterm);
        end else begin
            wr_addr = r_addr_r;
            wr_data = combine(r_op, r_mem_q, r_rterm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= t_action'(i_action);
            r_last    <= i_last_row;
            r_rd_ok   <= is_read && idx_ok;
            r_rd_l_en <= is_read ? idx_ok : (row_ok && col_l_ok);
            r_addr_a  <= is_read ? AW'(i_read_index)
                                 : AW'(base + PW'(col_l[COL_W-2:0]));
            r_addr_l  <= AW'(base + PW'(col_l[COL_W-2:0]));
            r_addr_r  <= AW'(base + PW'(col_r[COL_W-1:0]));
            r_lterm   <= lterm;
            r_rterm   <= rterm;
        end
        if (i_cmd.out_load) begin
            r_out_data <= r_rd_ok ? r_mem_q : '0;
            r_out_done <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_wr_l_en   <= 1'b0;
            r_wr_r_en   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr && !o_stat.clr_last) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (i_cmd.load) begin
                r_wr_l_en <= !is_read && row_ok && col_l_ok;
                r_wr_r_en <= !is_read && row_ok && col_r_ok;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.clr_last = r_clr_cnt == AW'(STORE_WORDS - 1);
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_out_data;
    assign o_sprite_done   = r_out_done;

`ifndef SYNTHESIS
    a_no_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("frame store read and write hit the same word");

    a_left_rmw_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_l |-> $past(i_cmd.rd_l))
        else $error("left word written without a read in the cycle before");

    a_clear_before_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (r_clr_cnt == AW'(STORE_WORDS - 1)))
        else $error("item accepted before the frame store was cleared");
`endif

endmodule

// ===== sv/shifted_row_blit_raster_op.sv =====
// Shifted-row blitter: each item ORs, XORs or ANDs a 32-pixel sprite row into two
// neighboring words of a one-bit-per-pixel frame store, or reads one word back.
// After reset the block runs a clearing pass over all WORDS_PER_LINE*LINES words
// (8000 at default size) during which it accepts no item. After that each item
// goes through these steps: accept, read the left word, write the left word while
// reading the right one, write the right word, repeated until the result port is free.
// The steps are set by the frame store memory, which has one write port and a
// registered read. A result waits in an output register, and the next item is
// taken meanwhile. Depends on srb_pkg, srb_if, srb_ctrl and srb_dpath.
module shifted_row_blit_raster_op #(
    parameter int WORDS_PER_LINE = srb_pkg::DEF_WORDS_PER_LINE,
    parameter int LINES          = srb_pkg::DEF_LINES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    srb_item_if.sink     i_item,
    srb_result_if.source o_result
);
    import srb_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;

    srb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    srb_dpath #(
        .WORDS_PER_LINE (WORDS_PER_LINE),
        .LINES          (LINES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_action       (i_item.action),
        .i_x_pos        (i_item.x_pos),
        .i_row_pos      (i_item.row_pos),
        .i_pattern      (i_item.pattern),
        .i_read_index   (i_item.read_index),
        .i_last_row     (i_item.last_row),
        .i_out_ready    (o_result.ready),
        .o_out_valid    (o_result.valid),
        .o_read_data    (o_result.read_data),
        .o_sprite_done  (o_result.sprite_done)
    );

    assign i_item.ready = w_in_ready;

endmodule

// ===== sim/shifted_row_blit_raster_op_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for shifted_row_blit_raster_op: sprite rows and word reads
// go in, results are checked against a frame store kept here. Uses srb_pkg, srb_if.
module shifted_row_blit_raster_op_test;
    import srb_pkg::*;

    localparam int LINE_WORDS  = DEF_WORDS_PER_LINE;
    localparam int SCREEN_ROWS = DEF_LINES;
    localparam int STORE_SIZE  = LINE_WORDS * SCREEN_ROWS;
    localparam int RANDOM_PER_PHASE = 313;
    localparam int DRAIN_CYCLES     = 24;
    // The limit covers the clearing pass and allows for heavy idling on both sides.
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        t_action                     action;
        logic signed [XPOS_W-1:0]    x_pos;
        logic [ROW_W-1:0]            row_pos;
        logic [WORD_BITS-1:0]        pattern;
        logic [RIDX_W-1:0]           read_index;
        logic                        last_row;
    } t_row_item;

    typedef struct {
        logic [WORD_BITS-1:0] read_data;
        logic                 sprite_done;
    } t_blit_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    srb_item_if   item_ch ();
    srb_result_if result_ch ();

    shifted_row_blit_raster_op dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    logic [WORD_BITS-1:0] frame_copy [STORE_SIZE];
    t_row_item            pending_rows [$];
    t_row_item            row_on_bus;
    t_blit_result         awaited_results [$];
    t_blit_result         want;
    int unsigned          send_idle_pct  = 0;
    int unsigned          recv_stall_pct = 0;
    int unsigned          error_count    = 0;
    int unsigned          cycle_count    = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 50) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    // Applies one transaction to the local frame store and returns the result it causes.
    function automatic t_blit_result blit_or_read(input t_row_item it);
        t_blit_result         res;
        int                   x;
        int                   col;
        int                   idx;
        logic [4:0]           sh;
        logic [WORD_BITS-1:0] term;
        res.read_data   = '0;
        res.sprite_done = it.last_row;
        if (it.action == ACT_READ) begin
            if (it.read_index < STORE_SIZE) begin
                res.read_data = frame_copy[it.read_index];
            end
        end else if (it.row_pos < SCREEN_ROWS) begin
            x  = $signed(it.x_pos);
            sh = it.x_pos[4:0];
            for (int k = 0; k < 2; k++) begin
                col = (x >>> 5) + k;
                if (k == 0) begin
                    term = it.pattern >> sh;
                end else begin
                    // With no shift the whole row lands in the left word.
                    term = (sh == 0) ? '0 : it.pattern << (WORD_BITS - sh);
                end
                if (col >= 0 && col < LINE_WORDS) begin
                    idx = it.row_pos * LINE_WORDS + col;
                    case (it.action)
                        ACT_OR:  frame_copy[idx] = frame_copy[idx] | term;
                        ACT_XOR: frame_copy[idx] = frame_copy[idx] ^ term;
                        default: frame_copy[idx] = frame_copy[idx] & term;
                    endcase
                end
            end
        end
        return res;
    endfunction

    task automatic push_row(input t_action op, input int x, input int row,
                            input logic [31:0] pat, input int ridx, input bit last);
        t_row_item it;
        it.action     = op;
        it.x_pos      = XPOS_W'(x);
        it.row_pos    = ROW_W'(row);
        it.pattern    = pat;
        it.read_index = RIDX_W'(ridx);
        it.last_row   = last;
        pending_rows.push_back(it);
    endtask

    task automatic push_read(input int idx);
        push_row(ACT_READ, int'($urandom_range(2047)) - 1024, $urandom_range(511), $urandom,
                 idx, 1'($urandom_range(1)));
    endtask

    // One sprite of a few rows, followed by reads of some of the words it touched.
    task automatic add_sprite();
        int      x;
        int      y0;
        int      h;
        int      col;
        t_action op;
        x  = ($urandom_range(9) == 0) ? int'($urandom_range(2047)) - 1024
                                      : int'($urandom_range(671)) - 32;
        y0 = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(SCREEN_ROWS - 1);
        h  = $urandom_range(1, 8);
        op = t_action'($urandom_range(2));
        col = x >>> 5;
        for (int r = 0; r < h; r++) begin
            push_row(op, x, (y0 + r) % 512, $urandom, $urandom_range(8191), r == h - 1);
        end
        for (int r = 0; r < h; r++) begin
            if ($urandom_range(1) == 1 && y0 + r < SCREEN_ROWS) begin
                for (int k = 0; k < 2; k++) begin
                    if (col + k >= 0 && col + k < LINE_WORDS) begin
                        push_read((y0 + r) * LINE_WORDS + col + k);
                    end
                end
            end
        end
    endtask

    task automatic add_random_rows(input int count);
        int target;
        target = pending_rows.size() + count;
        while (pending_rows.size() < target) begin
            if ($urandom_range(4) == 0) begin
                push_row(t_action'($urandom_range(3)), int'($urandom_range(2047)) - 1024,
                         $urandom_range(511), $urandom, $urandom_range(8191),
                         1'($urandom_range(1)));
            end else begin
                add_sprite();
            end
        end
    endtask

    task automatic add_directed_rows();
        push_row(ACT_OR, 0, 0, 32'hFFFF_FFFF, 0, 1'b0);
        push_read(0);
        push_read(1);
        push_row(ACT_XOR, 5, 0, 32'hA5C3_0F81, 0, 1'b1);
        push_read(0);
        push_read(1);
        // AND with no shift clears the word to the right.
        push_row(ACT_AND, 0, 0, 32'h0F0F_F0F0, 0, 1'b1);
        push_read(0);
        push_read(1);
        push_row(ACT_OR, -32, 1, 32'hFFFF_FFFF, 0, 1'b0);
        push_row(ACT_OR, -1, 2, 32'h8000_0001, 0, 1'b1);
        push_row(ACT_OR, 607, 3, 32'hFFFF_FFFF, 0, 1'b0);
        push_row(ACT_XOR, 608, SCREEN_ROWS - 1, 32'hFFFF_FFFF, 0, 1'b1);
        push_row(ACT_OR, 639, 4, 32'hC000_0003, 0, 1'b0);
        push_row(ACT_OR, -1024, 5, 32'hFFFF_FFFF, 8191, 1'b1);
        push_row(ACT_OR, 1023, 6, 32'hFFFF_FFFF, 0, 1'b0);
        push_row(ACT_OR, 64, SCREEN_ROWS, 32'hFFFF_FFFF, 0, 1'b1);
        push_row(ACT_OR, 64, 511, 32'hFFFF_FFFF, 0, 1'b0);
        push_read(LINE_WORDS);
        push_read(2 * LINE_WORDS + LINE_WORDS - 1);
        push_read(3 * LINE_WORDS + LINE_WORDS - 1);
        push_read(STORE_SIZE - 1);
        push_read(STORE_SIZE);
        push_read(8191);
        push_read(4 * LINE_WORDS + LINE_WORDS - 1);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                awaited_results.push_back(blit_or_read(row_on_bus));
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (pending_rows.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    row_on_bus = pending_rows.pop_front();
                    item_ch.valid      <= 1'b1;
                    item_ch.action     <= row_on_bus.action;
                    item_ch.x_pos      <= row_on_bus.x_pos;
                    item_ch.row_pos    <= row_on_bus.row_pos;
                    item_ch.pattern    <= row_on_bus.pattern;
                    item_ch.read_index <= row_on_bus.read_index;
                    item_ch.last_row   <= row_on_bus.last_row;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (awaited_results.size() == 0) begin
                    flag_error($sformatf("unexpected transaction: data %h done %b",
                                         result_ch.read_data, result_ch.sprite_done));
                end else begin
                    want = awaited_results.pop_front();
                    if (result_ch.read_data !== want.read_data) begin
                        flag_error($sformatf("read_data %h, expected %h",
                                             result_ch.read_data, want.read_data));
                    end
                    if (result_ch.sprite_done !== want.sprite_done) begin
                        flag_error($sformatf("sprite_done %b, expected %b",
                                             result_ch.sprite_done, want.sprite_done));
                    end
                end
            end
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("shifted_row_blit_raster_op_test: done, errors");
            $finish;
        end
    end

    initial begin
        item_ch.valid      = 1'b0;
        item_ch.action     = '0;
        item_ch.x_pos      = '0;
        item_ch.row_pos    = '0;
        item_ch.pattern    = '0;
        item_ch.read_index = '0;
        item_ch.last_row   = 1'b0;
        result_ch.ready    = 1'b0;
        i_rst_n            = 1'b0;
        for (int i = 0; i < STORE_SIZE; i++) begin
            frame_copy[i] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            if (phase == 0) begin
                add_directed_rows();
            end
            add_random_rows(RANDOM_PER_PHASE);
            @(posedge i_clk);
            while (pending_rows.size() != 0 || item_ch.valid
                   || awaited_results.size() != 0) begin
                @(posedge i_clk);
            end
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && awaited_results.size() == 0) begin
            $display("shifted_row_blit_raster_op_test: done, clean");
        end else begin
            $display("shifted_row_blit_raster_op_test: done, errors");
        end
        $finish;
    end

endmodule
